[src/fscp_pkg.sv]
// Package for the format spec character parser.
// Holds the settings and result types, action and kind codes, flag masks
// and character constants. Depends on nothing.
`default_nettype none

package fscp_pkg;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] precision;
    logic [7:0]  fill;
    logic [8:0]  flags;
  } settings_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] arg_index;
    logic        arg_index_valid;
    settings_t   settings;
    logic        keep_format;
  } result_t;

  localparam logic [1:0] ACT_FEED = 2'd0;
  localparam logic [1:0] ACT_ESC  = 2'd1;
  localparam logic [1:0] ACT_ITEM = 2'd2;
  localparam logic [1:0] ACT_PASS = 2'd3;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_LOAD  = 2'd3;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_PRECISION = 2'd1;
  localparam logic [1:0] REG_FILL      = 2'd2;
  localparam logic [1:0] REG_FLAGS     = 2'd3;

  localparam logic [8:0] FL_LEFT     = 9'h001;
  localparam logic [8:0] FL_RIGHT    = 9'h002;
  localparam logic [8:0] FL_INTERNAL = 9'h004;
  localparam logic [8:0] FL_DEC      = 9'h008;
  localparam logic [8:0] FL_OCT      = 9'h010;
  localparam logic [8:0] FL_HEX      = 9'h020;
  localparam logic [8:0] FL_SCI      = 9'h040;
  localparam logic [8:0] FL_FIXED    = 9'h080;
  localparam logic [8:0] FL_SHOWBASE = 9'h100;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_W         = 8'h77;
  localparam logic [7:0] CH_P         = 8'h70;
  localparam logic [7:0] CH_L         = 8'h6C;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_I         = 8'h69;
  localparam logic [7:0] CH_D         = 8'h64;
  localparam logic [7:0] CH_O         = 8'h6F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_H         = 8'h68;
  localparam logic [7:0] CH_S         = 8'h73;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_X         = 8'h78;

  localparam settings_t SETTINGS_RESET = '{width: 16'd0, precision: 16'd6,
                                           fill: 8'd32, flags: 9'd8};

endpackage

`default_nettype wire

[src/format_spec_char_parser.sv]
// Top level of the format spec character parser: parse state, settings,
// configuration registers and a two-entry output stage (register and skid).
// Depends on fscp_pkg.
// Each result is registered in the output register, or in the skid entry.
// Throughput: one item per cycle while in_stall is low; the parse state updates
// in the accept cycle. The input stalls only while the skid entry is occupied.
// Synchronous reset clears parsing, empties the output stage and returns the
// configuration, live and saved settings to their reset values.
`default_nettype none

module format_spec_char_parser #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          ch,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               action,
  output logic [15:0]              arg_index,
  output logic                     arg_index_valid,
  output logic [15:0]              width,
  output logic [15:0]              precision,
  output logic [7:0]               fill,
  output logic [8:0]               format_flags,
  output logic                     keep_format,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import fscp_pkg::*;

  localparam int AccW = VALUE_BITS + 4;

  fscp_pkg::settings_t init_set, live, saved;
  fscp_pkg::settings_t live_next, saved_next;
  logic in_index, in_format, escape_pending, keep_flag;
  logic in_index_next, in_format_next, escape_pending_next, keep_flag_next;
  logic index_acc_valid, value_acc_valid;
  logic index_acc_valid_next, value_acc_valid_next;
  logic [VALUE_BITS-1:0] index_acc, value_acc;
  logic [VALUE_BITS-1:0] index_acc_next, value_acc_next;
  logic [1:0] act;
  logic       fin;
  logic       is_digit;
  logic [15:0] value_sat;
  logic [VALUE_BITS+15:0] index_wide, value_wide;
  fscp_pkg::result_t res_next, out_res, skid_res;
  logic skid_valid;
  logic accept, out_fire;

  function automatic logic [VALUE_BITS-1:0] acc_step(input logic [VALUE_BITS-1:0] v,
                                                     input logic [3:0] d);
    logic [AccW-1:0] wide;
    wide = ({4'b0, v} << 3) + ({4'b0, v} << 1) + AccW'(d);
    if (wide[AccW-1:VALUE_BITS] != 4'b0) begin
      return {VALUE_BITS{1'b1}};
    end
    return wide[VALUE_BITS-1:0];
  endfunction

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign value_wide = {16'b0, value_acc};
  assign value_sat = ((value_wide >> 16) != '0) ? 16'hFFFF : value_wide[15:0];

  always_comb begin
    live_next = live;
    saved_next = saved;
    in_index_next = in_index;
    in_format_next = in_format;
    escape_pending_next = escape_pending;
    keep_flag_next = keep_flag;
    index_acc_valid_next = index_acc_valid;
    index_acc_next = index_acc;
    value_acc_valid_next = value_acc_valid;
    value_acc_next = value_acc;
    act = ACT_FEED;
    fin = 1'b0;
    case (kind)
      KIND_CHAR: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (in_format) begin
            live_next.fill = ch;
            fin = 1'b1;
          end else if (in_index) begin
            in_index_next = 1'b0;
            in_format_next = 1'b1;
          end else begin
            act = ACT_ESC;
            fin = 1'b1;
          end
        end
        if (!fin && ch == CH_BACKSLASH) begin
          escape_pending_next = 1'b1;
          fin = 1'b1;
        end
        if (!fin && in_index_next) begin
          if (is_digit) begin
            index_acc_next = acc_step(index_acc_valid ? index_acc : '0, ch[3:0]);
            index_acc_valid_next = 1'b1;
            fin = 1'b1;
          end else if (ch == CH_RBRACE) begin
            act = ACT_ITEM;
            fin = 1'b1;
          end else begin
            in_index_next = 1'b0;
            in_format_next = 1'b1;
            if (ch == CH_COLON) begin
              fin = 1'b1;
            end
          end
        end
        if (!fin && in_format_next) begin
          fin = 1'b1;
          if (is_digit) begin
            value_acc_next = acc_step(value_acc_valid ? value_acc : '0, ch[3:0]);
            value_acc_valid_next = 1'b1;
          end else begin
            case (ch)
              CH_RBRACE: begin
                if (value_acc_valid) live_next.width = value_sat;
                act = ACT_ITEM;
              end
              CH_BANG: keep_flag_next = 1'b1;
              CH_MINUS: ;
              CH_W: if (value_acc_valid) live_next.width = value_sat;
              CH_P: if (value_acc_valid) live_next.precision = value_sat;
              CH_L: begin
                if (value_acc_valid) live_next.width = value_sat;
                live_next.flags = live.flags | FL_LEFT;
              end
              CH_R: begin
                if (value_acc_valid) live_next.width = value_sat;
                live_next.flags = live.flags | FL_RIGHT;
              end
              CH_I: begin
                if (value_acc_valid) live_next.width = value_sat;
                live_next.flags = live.flags | FL_INTERNAL;
              end
              CH_D: live_next.flags = live.flags | FL_DEC;
              CH_O: live_next.flags = live.flags | FL_OCT;
              CH_B, CH_H: live_next.flags = live.flags | FL_HEX;
              CH_S: live_next.flags = live.flags | FL_SCI;
              CH_F: live_next.flags = live.flags | FL_FIXED;
              CH_X: live_next.flags = live.flags | FL_SHOWBASE;
              default: live_next.fill = ch;
            endcase
            value_acc_valid_next = 1'b0;
            value_acc_next = '0;
          end
        end
        if (!fin) begin
          if (ch == CH_LBRACE) begin
            in_index_next = 1'b1;
            index_acc_valid_next = 1'b0;
            index_acc_next = '0;
          end else begin
            act = ACT_PASS;
          end
        end
      end
      KIND_BEGIN, KIND_DONE: begin
        if (kind == KIND_BEGIN) begin
          saved_next = live;
        end else if (!keep_flag) begin
          live_next = saved;
        end
        in_index_next = 1'b0;
        in_format_next = 1'b0;
        keep_flag_next = 1'b0;
        index_acc_valid_next = 1'b0;
        index_acc_next = '0;
        value_acc_valid_next = 1'b0;
        value_acc_next = '0;
      end
      KIND_LOAD: live_next = init_set;
      default: ;
    endcase
  end

  assign index_wide = {16'b0, index_acc_next};

  always_comb begin
    res_next.action = act;
    res_next.arg_index = index_acc_valid_next ? index_wide[15:0] : 16'd0;
    res_next.arg_index_valid = index_acc_valid_next;
    res_next.settings = live_next;
    res_next.keep_format = keep_flag_next;
  end

  assign in_stall = skid_valid;
  assign accept = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_set <= SETTINGS_RESET;
      live <= SETTINGS_RESET;
      saved <= SETTINGS_RESET;
      in_index <= 1'b0;
      in_format <= 1'b0;
      escape_pending <= 1'b0;
      keep_flag <= 1'b0;
      index_acc_valid <= 1'b0;
      index_acc <= '0;
      value_acc_valid <= 1'b0;
      value_acc <= '0;
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH: init_set.width <= cfg_data;
          REG_PRECISION: init_set.precision <= cfg_data;
          REG_FILL: init_set.fill <= cfg_data[7:0];
          REG_FLAGS: init_set.flags <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (accept) begin
        live <= live_next;
        saved <= saved_next;
        in_index <= in_index_next;
        in_format <= in_format_next;
        escape_pending <= escape_pending_next;
        keep_flag <= keep_flag_next;
        index_acc_valid <= index_acc_valid_next;
        index_acc <= index_acc_next;
        value_acc_valid <= value_acc_valid_next;
        value_acc <= value_acc_next;
      end
      if (skid_valid) begin
        if (out_fire) begin
          out_res <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid || out_fire) begin
          out_res <= res_next;
          out_valid <= 1'b1;
        end else begin
          skid_res <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign action = out_res.action;
  assign arg_index = out_res.arg_index;
  assign arg_index_valid = out_res.arg_index_valid;
  assign width = out_res.settings.width;
  assign precision = out_res.settings.precision;
  assign fill = out_res.settings.fill;
  assign format_flags = out_res.settings.flags;
  assign keep_format = out_res.keep_format;

endmodule

`default_nettype wire
